// ===== design/nfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package nfs_pkg;

  localparam int unsigned TABLE_DEPTH_DEF     = 128;
  localparam int unsigned RATIO_FRAC_BITS_DEF = 24;

  localparam logic [1:0] CFG_BASE_NOTE  = 2'd0;
  localparam logic [1:0] CFG_BASE_FREQ  = 2'd1;
  localparam logic [1:0] CFG_SCALE_SIZE = 2'd2;

  localparam logic [6:0]  BASE_NOTE_RST  = 7'd60;
  localparam logic [31:0] BASE_FREQ_RST  = 32'd17145893;
  localparam logic [7:0]  SCALE_SIZE_RST = 8'd0;
  localparam logic [31:0] FREQ_MAX       = 32'hFFFF_FFFF;

  typedef struct packed {
    logic in_ready;
    logic wr;
    logic start;
    logic q_step;
    logic fix;
    logic rd_entry;
    logic rd_period;
    logic cap_entry;
    logic cap_period;
    logic mul_entry;
    logic mul_period;
    logic mul_acc;
    logic div_init;
    logic div_step;
    logic div_done;
    logic out_load;
    logic out_ovf;
  } nfs_cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic       in_write;
    logic       n_zero;
    logic       k_neg;
    logic [7:0] kmag;
    logic       mul_ovf;
    logic       div_ovf;
    logic       per_zero;
    logic       out_full;
  } nfs_stat_t;

endpackage
`default_nettype wire

// ===== design/nfs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface nfs_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [6:0]  note;
  logic [6:0]  entry_index;
  logic [31:0] entry_ratio;
  modport source (output valid, action, note, entry_index, entry_ratio, input ready);
  modport sink   (input valid, action, note, entry_index, entry_ratio, output ready);
endinterface

interface nfs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] frequency;
  logic        overflow;
  modport source (output valid, frequency, overflow, input ready);
  modport sink   (input valid, frequency, overflow, output ready);
endinterface
`default_nettype wire

// ===== design/nfs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nfs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/nfs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nfs_ctrl #(
  parameter int unsigned RATIO_FRAC_BITS = 24
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire nfs_pkg::nfs_stat_t stat,
  output nfs_pkg::nfs_cmd_t     cmd
);
  import nfs_pkg::*;

  localparam int unsigned NW = 33 + RATIO_FRAC_BITS;
  localparam int unsigned BW = $clog2(NW);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_QDIV = 13'b0000000000010,
    S_FIX  = 13'b0000000000100,
    S_RDE  = 13'b0000000001000,
    S_RDP  = 13'b0000000010000,
    S_CAPP = 13'b0000000100000,
    S_MULE = 13'b0000001000000,
    S_MULP = 13'b0000010000000,
    S_MACC = 13'b0000100000000,
    S_DIVI = 13'b0001000000000,
    S_DIVS = 13'b0010000000000,
    S_DFIN = 13'b0100000000000,
    S_DONE = 13'b1000000000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [BW-1:0] bcnt_r, bcnt_nxt;
  logic [7:0]    cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bcnt_r  <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bcnt_r  <= bcnt_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    bcnt_nxt  = bcnt_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    cmd       = '0;
    cmd.out_ovf = ovf_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) begin
          if (stat.in_write) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.start = 1'b1;
            ovf_nxt   = 1'b0;
            bcnt_nxt  = BW'(7);
            state_nxt = stat.n_zero ? S_DONE : S_QDIV;
          end
        end
      end
      S_QDIV: begin
        cmd.q_step = 1'b1;
        bcnt_nxt   = bcnt_r - BW'(1);
        if (bcnt_r == '0) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = S_RDE;
      end
      S_RDE: begin
        cmd.rd_entry = 1'b1;
        state_nxt    = S_RDP;
      end
      S_RDP: begin
        cmd.rd_period = 1'b1;
        cmd.cap_entry = 1'b1;
        cnt_nxt       = stat.kmag;
        state_nxt     = S_CAPP;
      end
      S_CAPP: begin
        cmd.cap_period = 1'b1;
        state_nxt      = stat.k_neg ? S_DIVI : S_MULE;
      end
      S_MULE: begin
        cmd.mul_entry = 1'b1;
        state_nxt     = S_MACC;
      end
      S_MULP: begin
        cmd.mul_period = 1'b1;
        state_nxt      = S_MACC;
      end
      S_MACC: begin
        if (stat.mul_ovf) begin
          ovf_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.mul_acc = 1'b1;
          if (stat.k_neg || cnt_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            cnt_nxt   = cnt_r - 8'd1;
            state_nxt = S_MULP;
          end
        end
      end
      S_DIVI: begin
        if (stat.per_zero) begin
          ovf_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.div_init = 1'b1;
          bcnt_nxt     = BW'(NW - 1);
          state_nxt    = S_DIVS;
        end
      end
      S_DIVS: begin
        cmd.div_step = 1'b1;
        bcnt_nxt     = bcnt_r - BW'(1);
        if (bcnt_r == '0) begin
          state_nxt = S_DFIN;
        end
      end
      S_DFIN: begin
        if (stat.div_ovf) begin
          ovf_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.div_done = 1'b1;
          cnt_nxt      = cnt_r - 8'd1;
          state_nxt    = (cnt_r == 8'd1) ? S_MULE : S_DIVI;
        end
      end
      S_DONE: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== design/nfs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nfs_datapath #(
  parameter int unsigned TABLE_DEPTH     = 128,
  parameter int unsigned RATIO_FRAC_BITS = 24,
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  nfs_in_if.sink                  in_ch,
  nfs_out_if.source               out_ch,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata,
  input  wire nfs_pkg::nfs_cmd_t  cmd,
  output nfs_pkg::nfs_stat_t      stat,
  output logic                    ram_we,
  output logic [AW-1:0]           ram_waddr,
  output logic [31:0]             ram_wdata,
  output logic [AW-1:0]           ram_raddr,
  input  wire logic [31:0]        ram_rdata
);
  import nfs_pkg::*;

  localparam int unsigned RF = RATIO_FRAC_BITS;
  localparam int unsigned NW = 33 + RF;
  localparam logic [10:0] DEPTH_L = 11'(TABLE_DEPTH);
  localparam logic [63:0] HALF    = 64'(1) << (RF - 1);

  logic [6:0]    base_note_r;
  logic [31:0]   base_freq_r;
  logic [7:0]    scale_r;
  logic [7:0]    n_r, qnq_r, d_r, kmag_r;
  logic          neg_r;
  logic [8:0]    qrem_r;
  logic [31:0]   entry_r, period_r, v_r;
  logic [63:0]   prod_r;
  logic [32:0]   drem_r;
  logic [NW-1:0] dnq_r;
  logic [31:0]   out_freq_r;
  logic          out_ovf_r, out_valid_r;

  logic [7:0]    n_sel, mag, rr, nm1;
  logic [8:0]    off, off_neg, qt;
  logic          qge, dge;
  logic [63:0]   macc;
  logic [32:0]   dt;
  logic [15:0]   ra16, wa16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_note_r <= BASE_NOTE_RST;
      base_freq_r <= BASE_FREQ_RST;
      scale_r     <= SCALE_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_NOTE:  base_note_r <= cfg_wdata[6:0];
        CFG_BASE_FREQ:  base_freq_r <= cfg_wdata;
        CFG_SCALE_SIZE: scale_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign n_sel   = ({3'b0, scale_r} > DEPTH_L) ? DEPTH_L[7:0] : scale_r;
  assign off     = {2'b0, in_ch.note} - {2'b0, base_note_r} - 9'd1;
  assign off_neg = 9'd0 - off;
  assign mag     = off[8] ? off_neg[7:0] : off[7:0];
  assign qt      = {qrem_r[7:0], qnq_r[7]};
  assign qge     = qt >= {1'b0, n_r};
  assign rr      = qrem_r[7:0];
  assign nm1     = n_r - 8'd1;
  assign macc    = prod_r + HALF;
  assign dt      = {drem_r[31:0], dnq_r[NW-1]};
  assign dge     = dt >= {1'b0, period_r};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n_r    <= n_sel;
      neg_r  <= off[8];
      qrem_r <= '0;
      qnq_r  <= mag;
    end else if (cmd.q_step) begin
      qrem_r <= qge ? (qt - {1'b0, n_r}) : qt;
      qnq_r  <= {qnq_r[6:0], qge};
    end
    if (cmd.fix) begin
      if (!neg_r || rr == '0) begin
        d_r    <= neg_r ? 8'd0 : rr;
        kmag_r <= qnq_r;
      end else begin
        d_r    <= n_r - rr;
        kmag_r <= qnq_r + 8'd1;
      end
    end
    if (cmd.cap_entry)  entry_r  <= ram_rdata;
    if (cmd.cap_period) period_r <= ram_rdata;
    if (cmd.mul_entry)  prod_r   <= 64'(v_r) * 64'(entry_r);
    if (cmd.mul_period) prod_r   <= 64'(v_r) * 64'(period_r);
    if (cmd.div_init) begin
      drem_r <= '0;
      dnq_r  <= NW'({v_r, {RF{1'b0}}}) + NW'(period_r >> 1);
    end else if (cmd.div_step) begin
      drem_r <= dge ? (dt - {1'b0, period_r}) : dt;
      dnq_r  <= {dnq_r[NW-2:0], dge};
    end
    if (cmd.start)         v_r <= base_freq_r;
    else if (cmd.mul_acc)  v_r <= macc[RF+31:RF];
    else if (cmd.div_done) v_r <= dnq_r[31:0];
    if (cmd.out_load) begin
      out_freq_r <= cmd.out_ovf ? FREQ_MAX : v_r;
      out_ovf_r  <= cmd.out_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign ra16      = {8'b0, (cmd.rd_period ? nm1 : d_r)};
  assign wa16      = {9'b0, in_ch.entry_index};
  assign ram_raddr = ra16[AW-1:0];
  assign ram_waddr = wa16[AW-1:0];
  assign ram_wdata = in_ch.entry_ratio;
  assign ram_we    = cmd.wr && ({4'b0, in_ch.entry_index} < DEPTH_L);

  assign in_ch.ready      = cmd.in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.frequency = out_freq_r;
  assign out_ch.overflow  = out_ovf_r;

  always_comb begin
    stat          = '0;
    stat.in_valid = in_ch.valid;
    stat.in_write = in_ch.action;
    stat.n_zero   = (scale_r == '0);
    stat.k_neg    = neg_r;
    stat.kmag     = kmag_r;
    stat.mul_ovf  = |macc[63:32+RF];
    stat.div_ovf  = |dnq_r[NW-1:32];
    stat.per_zero = (period_r == '0);
    stat.out_full = out_valid_r && !out_ch.ready;
  end
endmodule
`default_nettype wire

// ===== design/note_to_frequency_scale_map.sv =====
// Note to frequency map over a loaded ratio table.
// Input channel in_ch: action 1 writes entry_ratio to table slot entry_index
// (slots at or beyond the table depth are dropped); action 0 converts note.
// Output channel out_ch: one frequency/overflow request per convert, none
// per write. Configuration: cfg_we/cfg_index/cfg_wdata, base_note,
// base_freq and scale_size, written while the block is idle.
// Timing: one item at a time. A write is done in the idle state that
// accepts it. A convert with zero scale size goes straight to the output.
// Otherwise a bit-serial offset division, table reads, then per period
// step a multiply (k >= 0, k+1 multiplies) or a bit-serial divide (k < 0,
// |k| divides, then one multiply). The period divider sets the worst case.
// The result sits in an output register; the next item is accepted while
// it waits, and a further result holds until the receiver takes it.
// Reset restores base_note 60, base_freq 261.626 Hz, scale_size 0 and
// clears the output; table contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module note_to_frequency_scale_map #(
  parameter int unsigned TABLE_DEPTH     = nfs_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned RATIO_FRAC_BITS = nfs_pkg::RATIO_FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  nfs_in_if.sink           in_ch,
  nfs_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  import nfs_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  nfs_cmd_t      cmd;
  nfs_stat_t     stat;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  nfs_ctrl #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  nfs_datapath #(
    .TABLE_DEPTH     (TABLE_DEPTH),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  nfs_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );
endmodule
`default_nettype wire

// ===== design/nfs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nfs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_frequency,
  input wire logic        out_overflow
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after a request");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_frequency == 32'hFFFF_FFFF)
    else $error("overflow without saturated frequency");
endmodule

bind note_to_frequency_scale_map nfs_checker u_nfs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_frequency (out_ch.frequency),
  .out_overflow  (out_ch.overflow)
);
`default_nettype wire
